[hw/rtl/cjs_pkg.sv]
// cjs_pkg: shared types and codes for the cpu job scheduler
// scheduling modes, event codes and field widths; no dependencies

package cjs_pkg;

    // field widths fixed by the command and result formats
    localparam int unsigned JOB_W   = 8;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SUM_W   = 40;
    localparam int unsigned KEY_W   = 16;

    // scheduling mode register
    typedef enum logic [1:0] {
        MODE_SJF      = 2'd0,
        MODE_PRIO     = 2'd1,
        MODE_SRTF     = 2'd2,
        MODE_PRIO_PRE = 2'd3
    } t_mode;

    // command codes
    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    // result event codes
    typedef enum logic [2:0] {
        EV_ACCEPTED   = 3'd0,
        EV_REJECTED   = 3'd1,
        EV_NO_CHANGE  = 3'd2,
        EV_DISPATCH   = 3'd3,
        EV_IDLE_START = 3'd4
    } t_event;

endpackage

[hw/rtl/cpu_job_scheduler_unit.sv]
// cpu_job_scheduler_unit: tick-driven job scheduler with ready table and statistics
// depends on cjs_pkg for widths, mode and event codes

// Takes one request per clock (busy is always low) and returns exactly one result
// per request, from the result register behind the input register, on a one-cycle
// o_result_valid strobe; the receiver cannot stall it. A request is registered, then
// decided by a combinational compare tree over the QUEUE_DEPTH ready slots plus the
// running job, so the rate is one request per cycle. The o_*_out statistics are the
// values after the strobed request. Mode writes (i_cfg_we) take effect on the next tick.

module cpu_job_scheduler_unit #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_wdata,
    // request side
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [cjs_pkg::JOB_W-1:0]     i_job_id,
    input  logic [cjs_pkg::BURST_W-1:0]   i_burst_len,
    input  logic [cjs_pkg::PRIO_W-1:0]    i_prio_level,
    // result side
    output logic                          o_result_valid,
    output logic [2:0]                    o_event_kind,
    output logic [cjs_pkg::TIME_W-1:0]    o_event_time,
    output logic [cjs_pkg::JOB_W-1:0]     o_run_id,
    output logic [cjs_pkg::TIME_W-1:0]    o_dispatch_wait,
    output logic [cjs_pkg::TIME_W-1:0]    o_worst_wait_out,
    output logic [cjs_pkg::SUM_W-1:0]     o_total_wait_out,
    output logic [cjs_pkg::TIME_W-1:0]    o_idle_count_out
);

    localparam int unsigned IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned NLEAF = 1 << IW;
    localparam int unsigned NNODE = 2 * NLEAF - 1;

    localparam logic [cjs_pkg::TIME_W-1:0] MAX32 = '1;
    localparam logic [cjs_pkg::SUM_W-1:0]  MAX40 = '1;

    typedef struct packed {
        logic                       vld;
        logic [cjs_pkg::KEY_W-1:0]  key;
        logic [cjs_pkg::JOB_W-1:0]  id;
        logic [IW-1:0]              idx;
    } t_node;

    // configuration register
    cjs_pkg::t_mode r_mode;

    // input register
    logic                         r_in_valid;
    logic                         r_in_cmd;
    logic [cjs_pkg::JOB_W-1:0]    r_in_job;
    logic [cjs_pkg::BURST_W-1:0]  r_in_burst;
    logic [cjs_pkg::PRIO_W-1:0]   r_in_prio;

    // ready table
    logic [QUEUE_DEPTH-1:0]       r_slot_valid;
    logic [cjs_pkg::JOB_W-1:0]    r_slot_job       [QUEUE_DEPTH];
    logic [cjs_pkg::BURST_W-1:0]  r_slot_remaining [QUEUE_DEPTH];
    logic [cjs_pkg::BURST_W-1:0]  r_slot_original  [QUEUE_DEPTH];
    logic [cjs_pkg::PRIO_W-1:0]   r_slot_priority  [QUEUE_DEPTH];
    logic [cjs_pkg::TIME_W-1:0]   r_slot_arrival   [QUEUE_DEPTH];

    // running job
    logic                         r_run_valid;
    logic [cjs_pkg::JOB_W-1:0]    r_run_job;
    logic [cjs_pkg::BURST_W-1:0]  r_run_remaining;
    logic [cjs_pkg::BURST_W-1:0]  r_run_original;
    logic [cjs_pkg::PRIO_W-1:0]   r_run_priority;
    logic [cjs_pkg::TIME_W-1:0]   r_run_arrival;

    // time and statistics
    logic [cjs_pkg::TIME_W-1:0]   r_time_now;
    logic                         r_idle_flag;
    logic [cjs_pkg::TIME_W-1:0]   r_idle_ticks;
    logic [cjs_pkg::TIME_W-1:0]   r_worst_wait;
    logic [cjs_pkg::SUM_W-1:0]    r_wait_sum;

    // result register
    logic                         r_out_valid;
    cjs_pkg::t_event              r_out_kind;
    logic [cjs_pkg::TIME_W-1:0]   r_out_time;
    logic [cjs_pkg::JOB_W-1:0]    r_out_run_id;
    logic [cjs_pkg::TIME_W-1:0]   r_out_wait;

    // next values
    logic                         n_run_valid;
    logic [cjs_pkg::JOB_W-1:0]    n_run_job;
    logic [cjs_pkg::BURST_W-1:0]  n_run_remaining;
    logic [cjs_pkg::BURST_W-1:0]  n_run_original;
    logic [cjs_pkg::PRIO_W-1:0]   n_run_priority;
    logic [cjs_pkg::TIME_W-1:0]   n_run_arrival;
    logic                         n_idle_flag;
    logic [cjs_pkg::TIME_W-1:0]   n_idle_ticks;
    logic [cjs_pkg::TIME_W-1:0]   n_worst_wait;
    logic [cjs_pkg::SUM_W-1:0]    n_wait_sum;
    cjs_pkg::t_event              n_out_kind;
    logic [cjs_pkg::JOB_W-1:0]    n_out_run_id;
    logic [cjs_pkg::TIME_W-1:0]   n_out_wait;

    // decision signals
    logic                         w_by_prio;
    logic                         w_free_found;
    logic [IW-1:0]                w_free_idx;
    logic [cjs_pkg::BURST_W-1:0]  w_arr_burst;
    logic                         w_do_arrive;
    logic                         w_do_dispatch;
    logic                         w_preempt;
    logic                         w_retire;
    logic                         w_alive;
    logic [cjs_pkg::TIME_W-1:0]   w_span;
    logic [cjs_pkg::TIME_W-1:0]   w_ret_wait;
    logic [cjs_pkg::SUM_W:0]      w_sum_ext;
    logic [cjs_pkg::KEY_W-1:0]    w_run_key;
    logic [cjs_pkg::TIME_W-1:0]   w_b_span;
    logic [cjs_pkg::TIME_W:0]     w_pw;
    logic [cjs_pkg::TIME_W:0]     w_pw_net;
    logic [cjs_pkg::JOB_W-1:0]    w_b_job;
    logic [cjs_pkg::BURST_W-1:0]  w_b_rem;
    logic [cjs_pkg::BURST_W-1:0]  w_b_orig;
    logic [cjs_pkg::PRIO_W-1:0]   w_b_prio;
    logic [cjs_pkg::TIME_W-1:0]   w_b_arr;
    t_node                        w_node [NNODE];
    t_node                        w_best;

    assign busy = 1'b0;
    assign w_by_prio = (r_mode == cjs_pkg::MODE_PRIO) || (r_mode == cjs_pkg::MODE_PRIO_PRE);

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cjs_pkg::MODE_SJF;
        end else if (i_cfg_we) begin
            r_mode <= cjs_pkg::t_mode'(i_cfg_wdata);
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_in_cmd   <= i_cmd;
            r_in_job   <= i_job_id;
            r_in_burst <= i_burst_len;
            r_in_prio  <= i_prio_level;
        end
    end

    // leaves of the selection tree, padding leaves are empty
    genvar g;
    generate
        for (g = 0; g < NLEAF; g++) begin : g_leaf
            if (g < QUEUE_DEPTH) begin : g_real
                assign w_node[NLEAF-1+g] = '{
                    vld: r_slot_valid[g],
                    key: w_by_prio ? {{(cjs_pkg::KEY_W-cjs_pkg::PRIO_W){1'b0}},
                                      r_slot_priority[g]}
                                   : r_slot_remaining[g],
                    id:  r_slot_job[g],
                    idx: IW'(g)
                };
            end else begin : g_pad
                assign w_node[NLEAF-1+g] = '{vld: 1'b0, key: '0, id: '0, idx: IW'(g)};
            end
        end

        // inner nodes: right wins only on a lower key, or equal key and lower id; full ties go to the lower slot
        for (g = 0; g < NLEAF - 1; g++) begin : g_inner
            logic w_right;
            assign w_right = w_node[2*g+2].vld && (!w_node[2*g+1].vld ||
                             (w_node[2*g+2].key < w_node[2*g+1].key) ||
                             ((w_node[2*g+2].key == w_node[2*g+1].key) &&
                              (w_node[2*g+2].id < w_node[2*g+1].id)));
            assign w_node[g] = w_right ? w_node[2*g+2] : w_node[2*g+1];
        end
    endgenerate

    assign w_best = w_node[0];

    // fields of the best ready job
    assign w_b_job  = r_slot_job[w_best.idx];
    assign w_b_rem  = r_slot_remaining[w_best.idx];
    assign w_b_orig = r_slot_original[w_best.idx];
    assign w_b_prio = r_slot_priority[w_best.idx];
    assign w_b_arr  = r_slot_arrival[w_best.idx];

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    assign w_arr_burst = (r_in_burst == '0) ? cjs_pkg::BURST_W'(1) : r_in_burst;
    assign w_do_arrive = r_in_valid && (r_in_cmd == cjs_pkg::CMD_ARRIVE) && w_free_found;

    // retire of a finished job
    assign w_retire   = r_run_valid && (r_run_remaining == '0);
    assign w_alive    = r_run_valid && !w_retire;
    assign w_span     = r_time_now - r_run_arrival;
    assign w_ret_wait = (w_span > cjs_pkg::TIME_W'(r_run_original))
                        ? w_span - cjs_pkg::TIME_W'(r_run_original) : '0;
    assign w_sum_ext  = {1'b0, r_wait_sum} + (cjs_pkg::SUM_W + 1)'(w_ret_wait);

    // dispatch or preempt decision
    assign w_run_key = (r_mode == cjs_pkg::MODE_PRIO_PRE)
                       ? {{(cjs_pkg::KEY_W-cjs_pkg::PRIO_W){1'b0}}, r_run_priority}
                       : r_run_remaining;
    assign w_preempt = w_alive && w_best.vld &&
                       ((r_mode == cjs_pkg::MODE_SRTF) || (r_mode == cjs_pkg::MODE_PRIO_PRE)) &&
                       ((w_best.key < w_run_key) ||
                        ((w_best.key == w_run_key) && (w_best.id < r_run_job)));
    assign w_do_dispatch = (!w_alive && w_best.vld) || w_preempt;

    // projected wait of the dispatched job, time difference taken modulo 2^32
    assign w_b_span = r_time_now - w_b_arr;
    assign w_pw     = {1'b0, w_b_span} + (cjs_pkg::TIME_W + 1)'(w_b_rem);
    assign w_pw_net = (w_pw > (cjs_pkg::TIME_W + 1)'(w_b_orig))
                      ? w_pw - (cjs_pkg::TIME_W + 1)'(w_b_orig) : '0;

    // arrival result and tick processing
    always_comb begin
        n_run_valid     = r_run_valid;
        n_run_job       = r_run_job;
        n_run_remaining = r_run_remaining;
        n_run_original  = r_run_original;
        n_run_priority  = r_run_priority;
        n_run_arrival   = r_run_arrival;
        n_idle_flag     = r_idle_flag;
        n_idle_ticks    = r_idle_ticks;
        n_worst_wait    = r_worst_wait;
        n_wait_sum      = r_wait_sum;
        n_out_kind      = cjs_pkg::EV_NO_CHANGE;
        n_out_run_id    = '0;
        n_out_wait      = '0;
        if (r_in_cmd == cjs_pkg::CMD_ARRIVE) begin
            n_out_kind = w_free_found ? cjs_pkg::EV_ACCEPTED : cjs_pkg::EV_REJECTED;
        end else begin
            if (w_retire) begin
                n_wait_sum = w_sum_ext[cjs_pkg::SUM_W] ? MAX40 : w_sum_ext[cjs_pkg::SUM_W-1:0];
            end
            n_run_valid = w_alive;
            if (w_do_dispatch) begin
                n_run_valid     = 1'b1;
                n_run_job       = w_b_job;
                n_run_remaining = w_b_rem;
                n_run_original  = w_b_orig;
                n_run_priority  = w_b_prio;
                n_run_arrival   = w_b_arr;
                n_out_wait      = w_pw_net[cjs_pkg::TIME_W] ? MAX32
                                                            : w_pw_net[cjs_pkg::TIME_W-1:0];
                if (n_out_wait > r_worst_wait) begin
                    n_worst_wait = n_out_wait;
                end
                n_idle_flag  = 1'b0;
                n_out_kind   = cjs_pkg::EV_DISPATCH;
                n_out_run_id = w_b_job;
            end else if (!w_alive && !r_idle_flag) begin
                n_idle_flag = 1'b1;
                n_out_kind  = cjs_pkg::EV_IDLE_START;
            end
            // execute one tick
            if (n_run_valid) begin
                if (n_run_remaining != '0) begin
                    n_run_remaining = n_run_remaining - cjs_pkg::BURST_W'(1);
                end
            end else if (r_idle_ticks != MAX32) begin
                n_idle_ticks = r_idle_ticks + cjs_pkg::TIME_W'(1);
            end
        end
    end

    // ready table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (w_do_arrive) begin
            r_slot_valid[w_free_idx] <= 1'b1;
        end else if (r_in_valid && (r_in_cmd == cjs_pkg::CMD_TICK) && w_do_dispatch) begin
            r_slot_valid[w_best.idx] <= w_preempt;
        end
        if (w_do_arrive) begin
            r_slot_job[w_free_idx]       <= r_in_job;
            r_slot_remaining[w_free_idx] <= w_arr_burst;
            r_slot_original[w_free_idx]  <= w_arr_burst;
            r_slot_priority[w_free_idx]  <= r_in_prio;
            r_slot_arrival[w_free_idx]   <= r_time_now;
        end else if (r_in_valid && (r_in_cmd == cjs_pkg::CMD_TICK) && w_preempt) begin
            r_slot_job[w_best.idx]       <= r_run_job;
            r_slot_remaining[w_best.idx] <= r_run_remaining;
            r_slot_original[w_best.idx]  <= r_run_original;
            r_slot_priority[w_best.idx]  <= r_run_priority;
            r_slot_arrival[w_best.idx]   <= r_run_arrival;
        end
    end

    // running job, time and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid     <= 1'b0;
            r_run_job       <= '0;
            r_run_remaining <= '0;
            r_run_original  <= '0;
            r_run_priority  <= '0;
            r_run_arrival   <= '0;
            r_time_now      <= '0;
            r_idle_flag     <= 1'b0;
            r_idle_ticks    <= '0;
            r_worst_wait    <= '0;
            r_wait_sum      <= '0;
        end else if (r_in_valid && (r_in_cmd == cjs_pkg::CMD_TICK)) begin
            r_run_valid     <= n_run_valid;
            r_run_job       <= n_run_job;
            r_run_remaining <= n_run_remaining;
            r_run_original  <= n_run_original;
            r_run_priority  <= n_run_priority;
            r_run_arrival   <= n_run_arrival;
            r_time_now      <= r_time_now + cjs_pkg::TIME_W'(1);
            r_idle_flag     <= n_idle_flag;
            r_idle_ticks    <= n_idle_ticks;
            r_worst_wait    <= n_worst_wait;
            r_wait_sum      <= n_wait_sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_out_kind   <= n_out_kind;
            r_out_time   <= r_time_now;
            r_out_run_id <= n_out_run_id;
            r_out_wait   <= n_out_wait;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_event_kind     = r_out_kind;
    assign o_event_time     = r_out_time;
    assign o_run_id         = r_out_run_id;
    assign o_dispatch_wait  = r_out_wait;
    assign o_worst_wait_out = r_worst_wait;
    assign o_total_wait_out = r_wait_sum;
    assign o_idle_count_out = r_idle_ticks;

endmodule
